// ===== rtl/chained_hash_set_insert_search_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the chained hash set
// Concurrent checks on clock with synchronous reset; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_SET_INSERT_SEARCH_TOP_MACROS_SVH
`define CHAINED_HASH_SET_INSERT_SEARCH_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CHS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CHS_ASSERT_NOW(label, ante, cons, msg)
`define CHS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/chs_pkg.sv =====
// ---------------------------------------------------------------------------
// chs_pkg
// Shared constants and types for the chained hash set.
// ---------------------------------------------------------------------------
package chs_pkg;

   // bucket count must be a power of two: the bucket is the low key bits
   localparam int BUCKETS       = 1024;
   localparam int POOL_ENTRIES  = 4096;
   localparam int KEY_WIDTH     = 32;
   localparam int COUNT_WIDTH   = 32;
   localparam int BUCKET_BITS   = $clog2(BUCKETS);
   localparam int NODE_BITS     = $clog2(POOL_ENTRIES);
   localparam int POOL_CNT_BITS = $clog2(POOL_ENTRIES + 1);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_WALK,
      ST_FINISH,
      ST_APPEND
   } chs_state_type;

   typedef struct packed {
      logic                 valid;
      logic [NODE_BITS-1:0] head;
   } bucket_entry_type;

   typedef struct packed {
      logic                 valid;
      logic [NODE_BITS-1:0] next;
   } node_link_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] key;
      node_link_type        link;
   } node_rd_type;

   typedef struct packed {
      logic                 key_en;
      logic                 link_en;
      logic [NODE_BITS-1:0] addr;
      logic [KEY_WIDTH-1:0] key;
      node_link_type        link;
   } node_wr_type;

endpackage

// ===== rtl/chs_req_if.sv =====
// ---------------------------------------------------------------------------
// chs_req_if
// Request channel: operation kind and signed key.
// ---------------------------------------------------------------------------
interface chs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [chs_pkg::KEY_WIDTH-1:0] key;

   modport source (output valid, output kind, output key, input ready);
   modport sink   (input valid, input kind, input key, output ready);
endinterface

// ===== rtl/chs_rsp_if.sv =====
// ---------------------------------------------------------------------------
// chs_rsp_if
// Response channel: lookup flags and running totals.
// ---------------------------------------------------------------------------
interface chs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           bucket_occupied;
   logic                           key_present;
   logic                           pool_full;
   logic [chs_pkg::COUNT_WIDTH-1:0] collision_total;
   logic [chs_pkg::COUNT_WIDTH-1:0] hit_total;

   modport source (output valid, output bucket_occupied, output key_present,
                   output pool_full, output collision_total, output hit_total,
                   input ready);
   modport sink   (input valid, input bucket_occupied, input key_present,
                   input pool_full, input collision_total, input hit_total,
                   output ready);
endinterface

// ===== rtl/chs_node_ram.sv =====
// ---------------------------------------------------------------------------
// chs_node_ram
// Node pool storage: key array and link array, one read and one write port.
// ---------------------------------------------------------------------------
module chs_node_ram (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [chs_pkg::NODE_BITS-1:0] rd_addr,
   output chs_pkg::node_rd_type          rd_data,
   input  chs_pkg::node_wr_type          wr
);

   logic [chs_pkg::KEY_WIDTH-1:0] key_mem  [chs_pkg::POOL_ENTRIES];
   chs_pkg::node_link_type        link_mem [chs_pkg::POOL_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.key_en) begin
         key_mem[wr.addr] <= wr.key;
      end
      if (wr.link_en) begin
         link_mem[wr.addr] <= wr.link;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data.key  <= key_mem[rd_addr];
         rd_data.link <= link_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/chained_hash_set_insert_search_top.sv =====
// ---------------------------------------------------------------------------
// chained_hash_set_insert_search_top
// Hash set of signed 32-bit keys, separate chaining, insert and search.
// ---------------------------------------------------------------------------
// Usage: after reset the block sweeps the 1024-entry bucket table to empty,
// one bucket a cycle, with req_ch.ready low until it is done. Then one request
// is handled at a time. The bucket is the key's low 10 bits (floor modulo of
// the signed key). A request steps through the bucket read, the head check, a
// walk step per chain node compared (a hit stops the walk on the matching
// node) and the finishing step, plus an append step when a new key is linked
// behind an existing tail. The walk reads one node from the node RAM and
// checks it with the one key comparator per cycle. A finished response sits
// in an output register, so the next request can be taken while it waits;
// only the finishing step stalls when the previous response is not yet taken.
// ---------------------------------------------------------------------------
`include "chained_hash_set_insert_search_top_macros.svh"

module chained_hash_set_insert_search_top (
   input logic        clock,
   input logic        reset,
   chs_req_if.sink    req_ch,
   chs_rsp_if.source  rsp_ch
);

   // sequencer
   chs_pkg::chs_state_type state_ff, state_in;

   // request being worked on
   logic                              kind_ff, kind_in;
   logic [chs_pkg::KEY_WIDTH-1:0]     key_ff, key_in;
   logic [chs_pkg::BUCKET_BITS-1:0]   bucket_ff, bucket_in;

   // walk results
   logic                              occupied_ff, occupied_in;
   logic                              present_ff, present_in;
   logic [chs_pkg::NODE_BITS-1:0]     cur_ff, cur_in;
   logic [chs_pkg::NODE_BITS-1:0]     tail_ff, tail_in;
   logic [chs_pkg::NODE_BITS-1:0]     new_node_ff, new_node_in;

   // clear sweep pointer
   logic [chs_pkg::BUCKET_BITS-1:0]   clr_ff, clr_in;

   // persistent counters
   logic [chs_pkg::POOL_CNT_BITS-1:0] pool_used_ff, pool_used_in;
   logic [chs_pkg::COUNT_WIDTH-1:0]   collision_ff, collision_in;
   logic [chs_pkg::COUNT_WIDTH-1:0]   hit_ff, hit_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_occ_ff, rsp_occ_in;
   logic                              rsp_present_ff, rsp_present_in;
   logic                              rsp_full_ff, rsp_full_in;
   logic [chs_pkg::COUNT_WIDTH-1:0]   rsp_coll_ff, rsp_coll_in;
   logic [chs_pkg::COUNT_WIDTH-1:0]   rsp_hit_ff, rsp_hit_in;

   // bucket table
   chs_pkg::bucket_entry_type         bucket_mem [chs_pkg::BUCKETS];
   chs_pkg::bucket_entry_type         bkt_rd_ff;
   logic                              bkt_rd_en;
   logic [chs_pkg::BUCKET_BITS-1:0]   bkt_rd_addr;
   logic                              bkt_wr_en;
   logic [chs_pkg::BUCKET_BITS-1:0]   bkt_wr_addr;
   chs_pkg::bucket_entry_type         bkt_wr_data;

   // node pool
   logic                              node_rd_en;
   logic [chs_pkg::NODE_BITS-1:0]     node_rd_addr;
   chs_pkg::node_rd_type              node_rd;
   chs_pkg::node_wr_type              node_wr;

   // finishing step
   logic                              finish_go;
   logic                              is_insert;
   logic                              pool_exhausted;
   logic                              do_store;
   logic                              key_match;
   logic                              hit_step;

   chs_node_ram u_node_ram (
      .clock   (clock),
      .rd_en   (node_rd_en),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd),
      .wr      (node_wr)
   );

   // bucket table, registered read
   always_ff @(posedge clock) begin
      if (bkt_wr_en) begin
         bucket_mem[bkt_wr_addr] <= bkt_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_rd_en) begin
         bkt_rd_ff <= bucket_mem[bkt_rd_addr];
      end
   end

   // the shared key comparator used on every walk step
   assign key_match = (node_rd.key == key_ff);

   assign is_insert      = (kind_ff == chs_pkg::KIND_INSERT);
   assign pool_exhausted = (pool_used_ff ==
                            chs_pkg::POOL_CNT_BITS'(chs_pkg::POOL_ENTRIES));
   assign do_store       = is_insert && !present_ff && !pool_exhausted;
   assign finish_go      = !rsp_valid_ff || rsp_ch.ready;
   assign hit_step       = (state_ff == chs_pkg::ST_FINISH) && finish_go &&
                           !is_insert && present_ff;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      bucket_in      = bucket_ff;
      occupied_in    = occupied_ff;
      present_in     = present_ff;
      cur_in         = cur_ff;
      tail_in        = tail_ff;
      new_node_in    = new_node_ff;
      clr_in         = clr_ff;
      pool_used_in   = pool_used_ff;
      collision_in   = collision_ff;
      hit_in         = hit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_occ_in     = rsp_occ_ff;
      rsp_present_in = rsp_present_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_coll_in    = rsp_coll_ff;
      rsp_hit_in     = rsp_hit_ff;

      req_ch.ready   = 1'b0;
      bkt_rd_en      = 1'b0;
      bkt_rd_addr    = req_ch.key[chs_pkg::BUCKET_BITS-1:0];
      bkt_wr_en      = 1'b0;
      bkt_wr_addr    = bucket_ff;
      bkt_wr_data    = '0;
      node_rd_en     = 1'b0;
      node_rd_addr   = bkt_rd_ff.head;
      node_wr        = '0;

      case (state_ff)
         chs_pkg::ST_CLEAR: begin
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = clr_ff;
            clr_in      = clr_ff + chs_pkg::BUCKET_BITS'(1);
            if (clr_ff == '1) begin
               state_in = chs_pkg::ST_IDLE;
            end
         end

         chs_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               kind_in    = req_ch.kind;
               key_in     = req_ch.key;
               bucket_in  = req_ch.key[chs_pkg::BUCKET_BITS-1:0];
               bkt_rd_en  = 1'b1;
               present_in = 1'b0;
               state_in   = chs_pkg::ST_HEAD;
            end
         end

         chs_pkg::ST_HEAD: begin
            occupied_in = bkt_rd_ff.valid;
            if (bkt_rd_ff.valid) begin
               node_rd_en   = 1'b1;
               node_rd_addr = bkt_rd_ff.head;
               cur_in       = bkt_rd_ff.head;
               state_in     = chs_pkg::ST_WALK;
            end else begin
               state_in = chs_pkg::ST_FINISH;
            end
         end

         chs_pkg::ST_WALK: begin
            if (key_match) begin
               present_in = 1'b1;
               state_in   = chs_pkg::ST_FINISH;
            end else begin
               tail_in = cur_ff;
               if (node_rd.link.valid) begin
                  node_rd_en   = 1'b1;
                  node_rd_addr = node_rd.link.next;
                  cur_in       = node_rd.link.next;
               end else begin
                  state_in = chs_pkg::ST_FINISH;
               end
            end
         end

         chs_pkg::ST_FINISH: begin
            if (finish_go) begin
               collision_in = collision_ff +
                              chs_pkg::COUNT_WIDTH'(is_insert && occupied_ff);
               hit_in       = hit_ff + chs_pkg::COUNT_WIDTH'(hit_step);

               rsp_valid_in   = 1'b1;
               rsp_occ_in     = occupied_ff;
               rsp_present_in = present_ff;
               rsp_full_in    = is_insert && !present_ff && pool_exhausted;
               rsp_coll_in    = collision_in;
               rsp_hit_in     = hit_in;

               state_in = chs_pkg::ST_IDLE;
               if (do_store) begin
                  // new node, terminated link
                  node_wr.key_en  = 1'b1;
                  node_wr.link_en = 1'b1;
                  node_wr.addr    = pool_used_ff[chs_pkg::NODE_BITS-1:0];
                  node_wr.key     = key_ff;
                  node_wr.link    = '0;
                  new_node_in     = pool_used_ff[chs_pkg::NODE_BITS-1:0];
                  pool_used_in    = pool_used_ff + chs_pkg::POOL_CNT_BITS'(1);
                  if (occupied_ff) begin
                     state_in = chs_pkg::ST_APPEND;
                  end else begin
                     bkt_wr_en         = 1'b1;
                     bkt_wr_addr       = bucket_ff;
                     bkt_wr_data.valid = 1'b1;
                     bkt_wr_data.head  = pool_used_ff[chs_pkg::NODE_BITS-1:0];
                  end
               end
            end
         end

         chs_pkg::ST_APPEND: begin
            // hook the new node behind the chain tail
            node_wr.link_en    = 1'b1;
            node_wr.addr       = tail_ff;
            node_wr.link.valid = 1'b1;
            node_wr.link.next  = new_node_ff;
            state_in           = chs_pkg::ST_IDLE;
         end

         default: begin
            state_in = chs_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chs_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pool_used_ff <= '0;
         collision_ff <= '0;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pool_used_ff <= pool_used_in;
         collision_ff <= collision_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      bucket_ff      <= bucket_in;
      occupied_ff    <= occupied_in;
      present_ff     <= present_in;
      cur_ff         <= cur_in;
      tail_ff        <= tail_in;
      new_node_ff    <= new_node_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_present_ff <= rsp_present_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_coll_ff    <= rsp_coll_in;
      rsp_hit_ff     <= rsp_hit_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.bucket_occupied = rsp_occ_ff;
   assign rsp_ch.key_present     = rsp_present_ff;
   assign rsp_ch.pool_full       = rsp_full_ff;
   assign rsp_ch.collision_total = rsp_coll_ff;
   assign rsp_ch.hit_total       = rsp_hit_ff;

   // checks
   `CHS_ASSERT_NOW(a_full_not_dup, rsp_ch.valid && rsp_ch.pool_full, !rsp_ch.key_present, "pool full flagged on a key already stored")
   `CHS_ASSERT_NEXT(a_search_no_alloc, (state_ff == chs_pkg::ST_FINISH) && !is_insert, $stable(pool_used_ff), "search allocated a node")
   `CHS_ASSERT_NOW(a_hit_only_on_hit, !$stable(hit_ff), $past(hit_step), "hit count moved without a search hit")
   `CHS_ASSERT_NOW(a_pool_bound, state_ff == chs_pkg::ST_APPEND, pool_used_ff != '0, "append with no node allocated")

endmodule

// ===== tb/tb_chained_hash_set_insert_search_top.sv =====
// ---------------------------------------------------------------------------
// tb_chained_hash_set_insert_search_top
// Self-checking bench for the chained hash set: inserts and searches of
// signed keys are mirrored in a behavioural copy of the bucket table and node
// pool, and every response is compared field by field with the prediction.
// Covers corner keys, random mixed traffic with long chains, and a long output
// stall that backs up the request side.
// ---------------------------------------------------------------------------
module tb_chained_hash_set_insert_search_top;

   localparam int WATCHDOG_LIMIT     = 20000; // quiet cycles before giving up
   localparam int IDLE_MAX           = 11;
   localparam int RANDOM_ITEMS       = 550;
   localparam int LONG_HOLD          = 400;   // receiver stall for the pressure test
   localparam int SETTLE_CYCLES      = 40;

   // one response as the set should report it
   typedef struct {
      logic                            bucket_occupied;
      logic                            key_present;
      logic                            pool_full;
      logic [chs_pkg::COUNT_WIDTH-1:0] collision_total;
      logic [chs_pkg::COUNT_WIDTH-1:0] hit_total;
   } set_outcome_type;

   logic clock;
   logic reset = 1'b1;

   chs_req_if req_ch ();
   chs_rsp_if rsp_ch ();

   chained_hash_set_insert_search_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the set: bucket heads, node pool, bump pointer, totals
   // ------------------------------------------------------------------
   bit                              head_valid  [chs_pkg::BUCKETS];
   int unsigned                     head_slot   [chs_pkg::BUCKETS];
   logic [chs_pkg::KEY_WIDTH-1:0]   slot_key    [chs_pkg::POOL_ENTRIES];
   bit                              slot_linked [chs_pkg::POOL_ENTRIES];
   int unsigned                     slot_next   [chs_pkg::POOL_ENTRIES];
   int unsigned                     slots_taken = 0;
   logic [chs_pkg::COUNT_WIDTH-1:0] collision_tally = '0;
   logic [chs_pkg::COUNT_WIDTH-1:0] hit_tally = '0;

   // keys currently in the set, for picking hits and duplicates
   logic signed [chs_pkg::KEY_WIDTH-1:0] stored_keys [$];

   // predictions waiting for their response, oldest first
   set_outcome_type outcome_q [$];

   // knobs shared between the request driver, the response sink and the tests
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int rsp_hold_request = 0;

   // run statistics
   int error_count     = 0;
   int requests_sent   = 0;
   int inserts_sent    = 0;
   int searches_sent   = 0;
   int responses_seen  = 0;
   int dup_inserts     = 0;
   int dropped_inserts = 0;
   int long_holds      = 0;
   int unsigned longest_walk = 0;

   // Applies one request to the shadow set and returns what the block should say.
   // The bucket is the floor modulo of the signed key; the walk stops on a match
   // or at the tail, and is capped at the pool size.
   function automatic set_outcome_type hash_set_apply(
      input logic                                 kind_in,
      input logic signed [chs_pkg::KEY_WIDTH-1:0] key_in
   );
      set_outcome_type res;
      int              bucket;
      int unsigned     cur;
      int unsigned     tail;
      int unsigned     steps;
      bit              occupied;
      bit              found;
      bit              have_tail;

      bucket = key_in % chs_pkg::BUCKETS;
      if (bucket < 0) bucket += chs_pkg::BUCKETS;
      occupied  = head_valid[bucket];
      found     = 1'b0;
      have_tail = 1'b0;
      tail      = 0;
      steps     = 0;

      if (occupied) begin
         cur = head_slot[bucket];
         while (steps < chs_pkg::POOL_ENTRIES) begin
            steps++;
            if (slot_key[cur] == key_in) begin
               found = 1'b1;
               break;
            end
            tail      = cur;
            have_tail = 1'b1;
            if (!slot_linked[cur]) break;
            cur = slot_next[cur];
         end
      end
      if (steps > longest_walk) longest_walk = steps;

      res.bucket_occupied = occupied;
      res.key_present     = found;
      res.pool_full       = 1'b0;

      if (kind_in == chs_pkg::KIND_SEARCH) begin
         if (found) hit_tally++;
      end else begin
         // every insert into a non-empty bucket counts, duplicates and drops too
         if (occupied) collision_tally++;
         if (!found) begin
            if (slots_taken >= chs_pkg::POOL_ENTRIES) begin
               res.pool_full = 1'b1;
            end else begin
               slot_key[slots_taken]    = key_in;
               slot_linked[slots_taken] = 1'b0;
               slot_next[slots_taken]   = 0;
               if (occupied && have_tail) begin
                  slot_linked[tail] = 1'b1;
                  slot_next[tail]   = slots_taken;
               end else begin
                  head_valid[bucket] = 1'b1;
                  head_slot[bucket]  = slots_taken;
               end
               stored_keys.push_back(key_in);
               slots_taken++;
            end
         end
      end

      res.collision_total = collision_tally;
      res.hit_total       = hit_tally;
      return res;
   endfunction

   function automatic logic signed [chs_pkg::KEY_WIDTH-1:0] pick_stored_key();
      return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
   endfunction

   // Random key: half well-formed traffic (stored keys, crowded buckets), the
   // rest fresh full-range keys and small values either side of zero.
   function automatic logic signed [chs_pkg::KEY_WIDTH-1:0] random_key();
      int                                   sel;
      int                                   crowded [4];
      logic signed [chs_pkg::KEY_WIDTH-1:0] k;

      crowded = '{0, 1, chs_pkg::BUCKETS / 2, chs_pkg::BUCKETS - 1};
      sel = $urandom_range(0, 99);
      if (sel < 35 || stored_keys.size() == 0) begin
         k = $urandom();
      end else if (sel < 60) begin
         k = pick_stored_key();
      end else if (sel < 85) begin
         k = $urandom();
         k[chs_pkg::BUCKET_BITS-1:0] =
            chs_pkg::BUCKET_BITS'(crowded[$urandom_range(0, 3)]);
      end else begin
         k = $urandom_range(0, 4095) - 2048;
      end
      return k;
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Entered and left just after a falling edge; valid is
   // left high on return so back-to-back requests never drop it for a step.
   // The prediction is made on the edge at which the request is taken.
   // ------------------------------------------------------------------
   task automatic send_request(
      input logic                                 kind_in,
      input logic signed [chs_pkg::KEY_WIDTH-1:0] key_in
   );
      int              gap;
      set_outcome_type res;

      gap = req_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind_in;
      req_ch.key   <= key_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);

      res = hash_set_apply(kind_in, key_in);
      outcome_q.push_back(res);
      requests_sent++;
      if (kind_in == chs_pkg::KIND_SEARCH) begin
         searches_sent++;
      end else begin
         inserts_sent++;
         if (res.key_present) dup_inserts++;
         if (res.pool_full) dropped_inserts++;
      end
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response sink: random stall per response, plus a one-off long hold
   // when a test asks for one, counted here in its own cycles.
   // ------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      int hold;

      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_request > 0) begin
            hold = rsp_hold_request;
            rsp_hold_request = 0;
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(negedge clock);
            long_holds++;
         end
         stall = rsp_idle ? $urandom_range(0, IDLE_MAX) : 0;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------
   // Response checker
   // ------------------------------------------------------------------
   set_outcome_type want;

   task automatic compare_field(
      input string                           what,
      input logic [chs_pkg::COUNT_WIDTH-1:0] want_v,
      input logic [chs_pkg::COUNT_WIDTH-1:0] got_v
   );
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (outcome_q.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding, expected none, got one",
                     $time);
         end else begin
            want = outcome_q.pop_front();
            compare_field("bucket_occupied",
                          chs_pkg::COUNT_WIDTH'(want.bucket_occupied),
                          chs_pkg::COUNT_WIDTH'(rsp_ch.bucket_occupied));
            compare_field("key_present",
                          chs_pkg::COUNT_WIDTH'(want.key_present),
                          chs_pkg::COUNT_WIDTH'(rsp_ch.key_present));
            compare_field("pool_full",
                          chs_pkg::COUNT_WIDTH'(want.pool_full),
                          chs_pkg::COUNT_WIDTH'(rsp_ch.pool_full));
            compare_field("collision_total", want.collision_total, rsp_ch.collision_total);
            compare_field("hit_total", want.hit_total, rsp_ch.hit_total);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: the bucket sweep after reset, the long hold and the longest
   // chain walk all sit well inside the limit.
   // ------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request or response moved for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Corner keys: empty-bucket miss, first insert, duplicate, extreme keys that
   // share bucket 0 and the top bucket, negative keys wrapping via floor modulo,
   // hits at head, middle and tail of a chain, misses in an occupied bucket.
   task automatic test_directed_corners();
      send_request(chs_pkg::KIND_SEARCH, 32'sd0);
      send_request(chs_pkg::KIND_INSERT, 32'sd0);
      send_request(chs_pkg::KIND_INSERT, 32'sd0);
      send_request(chs_pkg::KIND_SEARCH, 32'sd0);
      send_request(chs_pkg::KIND_INSERT, 32'sh8000_0000);
      send_request(chs_pkg::KIND_INSERT, 32'sh7FFF_FFFF);
      send_request(chs_pkg::KIND_INSERT, -32'sd1);
      send_request(chs_pkg::KIND_INSERT, -32'sd1024);
      send_request(chs_pkg::KIND_INSERT, 32'sd1024);
      send_request(chs_pkg::KIND_SEARCH, 32'sd1024);
      send_request(chs_pkg::KIND_SEARCH, 32'sh8000_0000);
      send_request(chs_pkg::KIND_SEARCH, 32'sd2048);
      send_request(chs_pkg::KIND_SEARCH, -32'sd1);
      send_request(chs_pkg::KIND_SEARCH, 32'sd1023);
      send_request(chs_pkg::KIND_INSERT, -32'sd1025);
      send_request(chs_pkg::KIND_INSERT, 32'sd1);
      send_request(chs_pkg::KIND_SEARCH, -32'sd1023);
      send_request(chs_pkg::KIND_INSERT, 32'sh5555_5555);
      send_request(chs_pkg::KIND_INSERT, 32'shAAAA_AAAA);
      send_request(chs_pkg::KIND_SEARCH, 32'shAAAA_AAAA);
      send_request(chs_pkg::KIND_INSERT, 32'sh8000_0000);
      send_request(chs_pkg::KIND_SEARCH, 32'sh7FFF_FFFF);
      send_request(chs_pkg::KIND_SEARCH, 32'sh8000_0001);
   endtask

   // Mixed inserts and searches; both sides switch idling on and off in stretches.
   task automatic test_random_traffic();
      int n;

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            req_idle = ($urandom_range(0, 3) != 0);
            rsp_idle = ($urandom_range(0, 3) != 0);
         end
         send_request($urandom_range(0, 1) ? chs_pkg::KIND_SEARCH : chs_pkg::KIND_INSERT,
                      random_key());
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // Receiver holds off for a long stretch while requests keep coming with no
   // gaps, so the output register fills and the request side stalls.
   task automatic test_output_backpressure();
      int n;

      req_idle = 1'b0;
      rsp_hold_request = LONG_HOLD;
      for (n = 0; n < 30; n++)
         send_request($urandom_range(0, 1) ? chs_pkg::KIND_SEARCH : chs_pkg::KIND_INSERT,
                      random_key());
      req_idle = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind  = chs_pkg::KIND_INSERT;
      req_ch.key   = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_traffic();
      test_output_backpressure();

      req_ch.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests (%0d inserts, %0d searches), %0d responses checked.",
               requests_sent, inserts_sent, searches_sent, responses_seen);
      $display("Hits %0d, duplicate inserts %0d, dropped %0d, collisions %0d,",
               hit_tally, dup_inserts, dropped_inserts, collision_tally);
      $display("longest walk %0d, long holds %0d.", longest_walk, long_holds);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/chs_pkg.sv
rtl/chs_req_if.sv
rtl/chs_rsp_if.sv
rtl/chs_node_ram.sv
rtl/chained_hash_set_insert_search_top.sv
tb/tb_chained_hash_set_insert_search_top.sv
